>>> src/nearest_palette_color_search_defines.svh
// assertion macros for the nearest palette color search block
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nps_pkg.sv
// shared types and constants for the nearest palette color search block
`timescale 1ns / 1ps

package nps_pkg;

    localparam int CHAN_W    = 16;
    localparam int PIXEL_W   = 32;
    localparam int COUNT_W   = 9;
    localparam int SHIFT_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int WORD_W    = 3 * CHAN_W + 1;

    typedef logic [CHAN_W-1:0]    t_chan;
    typedef logic [PIXEL_W-1:0]   t_pixel;
    typedef logic [7:0]           t_entry_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_data;
    typedef logic [WORD_W-1:0]    t_word;

    localparam t_cfg_idx CFG_MAP_MODE    = 3'd0;
    localparam t_cfg_idx CFG_ENTRY_COUNT = 3'd1;
    localparam t_cfg_idx CFG_RED_SHIFT   = 3'd2;
    localparam t_cfg_idx CFG_GREEN_SHIFT = 3'd3;
    localparam t_cfg_idx CFG_BLUE_SHIFT  = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FIND  = 1'b1;

    localparam logic MODE_INDEXED = 1'b0;
    localparam logic MODE_DIRECT  = 1'b1;

endpackage

>>> src/nps_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/nearest_palette_color_search.sv
// nearest palette color search: palette store and sequential scan
//
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_ready     func, entry_index, rgb values, allocated
// out      out  o_out_valid / i_out_ready   pixel
// cfg      in   i_cfg_we                    i_cfg_index, i_cfg_data
//
// a write request leaves the block idle; a find request scans the active entries from
// the highest index down through the single ram read port, one entry per cycle
// a count of zero skips the scan; an indexed find stops early at an exact match
// after reset a clearing pass zeroes the palette; input not ready
// a finished result waits in the output register; writes are still taken meanwhile
// a find that ends while the output register is full holds with input not ready
`timescale 1ns / 1ps

`include "nearest_palette_color_search_defines.svh"

module nearest_palette_color_search #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_func,
    input  nps_pkg::t_entry_idx   i_in_entry_index,
    input  nps_pkg::t_chan        i_in_red_value,
    input  nps_pkg::t_chan        i_in_green_value,
    input  nps_pkg::t_chan        i_in_blue_value,
    input  logic                  i_in_allocated,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output nps_pkg::t_pixel       o_out_pixel,

    input  logic                  i_cfg_we,
    input  nps_pkg::t_cfg_idx     i_cfg_index,
    input  nps_pkg::t_cfg_data    i_cfg_data
);

    import nps_pkg::*;

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = IW + 1;
    localparam int SUM_W = CHAN_W + 2;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration
    logic               r_map_mode;
    logic [COUNT_W-1:0] r_entry_count;
    logic [SHIFT_W-1:0] r_red_shift;
    logic [SHIFT_W-1:0] r_green_shift;
    logic [SHIFT_W-1:0] r_blue_shift;

    // sequencer
    logic [1:0]         r_state, n_state;
    logic [IW-1:0]      r_addr, n_addr;
    logic               r_more, n_more;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_pidx, n_pidx;

    // request and best-so-far
    t_chan              r_want_r, r_want_g, r_want_b;
    t_chan              n_want_r, n_want_g, n_want_b;
    logic [IW-1:0]      r_best_i, n_best_i;
    logic [SUM_W-1:0]   r_best_sum, n_best_sum;
    logic [IW-1:0]      r_best_r, r_best_g, r_best_b;
    logic [IW-1:0]      n_best_r, n_best_g, n_best_b;
    logic [CHAN_W:0]    r_best_dr, r_best_dg, r_best_db;
    logic [CHAN_W:0]    n_best_dr, n_best_dg, n_best_db;

    // output register
    logic               r_out_valid, n_out_valid;
    t_pixel             r_out_pixel, n_out_pixel;

    // memory ports
    logic               w_ram_we;
    logic [IW-1:0]      w_ram_waddr;
    t_word              w_ram_wdata;
    t_word              w_ram_rdata;

    logic               w_in_acc;
    logic               w_idx_ok;
    logic [CW-1:0]      w_active;
    logic [CW-1:0]      w_last;
    t_chan              w_dr, w_dg, w_db;
    logic [SUM_W-1:0]   w_sum;
    logic               w_ent_alloc;
    t_pixel             w_pixel;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    assign w_idx_ok = (32'(i_in_entry_index) < 32'(MAX_ENTRIES));

    always_comb begin
        if (32'(r_entry_count) > 32'(MAX_ENTRIES)) begin
            w_active = CW'(MAX_ENTRIES);
        end else begin
            w_active = CW'(r_entry_count);
        end
        w_last = w_active - CW'(1);
    end

    // ram write port: clearing pass or palette write
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_addr;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_in_acc && (i_in_func == FUNC_WRITE) && w_idx_ok;
            w_ram_waddr = IW'(i_in_entry_index);
            w_ram_wdata = {i_in_allocated, i_in_red_value, i_in_green_value,
                           i_in_blue_value};
        end
    end

    nps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    // shared distance unit
    always_comb begin
        t_chan ent_r, ent_g, ent_b;
        ent_r = w_ram_rdata[3*CHAN_W-1:2*CHAN_W];
        ent_g = w_ram_rdata[2*CHAN_W-1:CHAN_W];
        ent_b = w_ram_rdata[CHAN_W-1:0];
        w_ent_alloc = w_ram_rdata[WORD_W-1];
        w_dr = (ent_r > r_want_r) ? ent_r - r_want_r : r_want_r - ent_r;
        w_dg = (ent_g > r_want_g) ? ent_g - r_want_g : r_want_g - ent_g;
        w_db = (ent_b > r_want_b) ? ent_b - r_want_b : r_want_b - ent_b;
        w_sum = SUM_W'(w_dr) + SUM_W'(w_dg) + SUM_W'(w_db);
    end

    always_comb begin
        if (r_map_mode == MODE_INDEXED) begin
            w_pixel = PIXEL_W'(r_best_i);
        end else begin
            w_pixel = (PIXEL_W'(r_best_r) << r_red_shift)
                    | (PIXEL_W'(r_best_g) << r_green_shift)
                    | (PIXEL_W'(r_best_b) << r_blue_shift);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_more      = r_more;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_want_r    = r_want_r;
        n_want_g    = r_want_g;
        n_want_b    = r_want_b;
        n_best_i    = r_best_i;
        n_best_sum  = r_best_sum;
        n_best_r    = r_best_r;
        n_best_g    = r_best_g;
        n_best_b    = r_best_b;
        n_best_dr   = r_best_dr;
        n_best_dg   = r_best_dg;
        n_best_db   = r_best_db;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pixel = r_out_pixel;

        case (r_state)
            ST_CLEAR: begin
                if (32'(r_addr) == 32'(MAX_ENTRIES - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            ST_IDLE: begin
                if (w_in_acc && (i_in_func == FUNC_FIND)) begin
                    n_want_r   = i_in_red_value;
                    n_want_g   = i_in_green_value;
                    n_want_b   = i_in_blue_value;
                    n_best_i   = '0;
                    n_best_r   = '0;
                    n_best_g   = '0;
                    n_best_b   = '0;
                    n_best_sum = '1;
                    n_best_dr  = '1;
                    n_best_dg  = '1;
                    n_best_db  = '1;
                    n_addr     = w_last[IW-1:0];
                    n_more     = 1'b1;
                    if (w_active == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_pend = r_more;
                n_pidx = r_addr;
                if (r_more) begin
                    if (r_addr == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr - IW'(1);
                    end
                end
                if (r_pend) begin
                    if (r_map_mode == MODE_INDEXED) begin
                        if (w_ent_alloc && (w_sum < r_best_sum)) begin
                            n_best_sum = w_sum;
                            n_best_i   = r_pidx;
                            // exact match ends the scan
                            if (w_sum == '0) begin
                                n_pend  = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                    end else begin
                        if ({1'b0, w_dr} < r_best_dr) begin
                            n_best_dr = {1'b0, w_dr};
                            n_best_r  = r_pidx;
                        end
                        if ({1'b0, w_dg} < r_best_dg) begin
                            n_best_dg = {1'b0, w_dg};
                            n_best_g  = r_pidx;
                        end
                        if ({1'b0, w_db} < r_best_db) begin
                            n_best_db = {1'b0, w_db};
                            n_best_b  = r_pidx;
                        end
                    end
                    if (!r_more) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = w_pixel;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_addr        <= '0;
            r_more        <= 1'b0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_map_mode    <= MODE_INDEXED;
            r_entry_count <= COUNT_W'(256);
            r_red_shift   <= SHIFT_W'(16);
            r_green_shift <= SHIFT_W'(8);
            r_blue_shift  <= SHIFT_W'(0);
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_more      <= n_more;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAP_MODE:    r_map_mode    <= i_cfg_data[0];
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_RED_SHIFT:   r_red_shift   <= i_cfg_data[SHIFT_W-1:0];
                    CFG_GREEN_SHIFT: r_green_shift <= i_cfg_data[SHIFT_W-1:0];
                    CFG_BLUE_SHIFT:  r_blue_shift  <= i_cfg_data[SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx      <= n_pidx;
        r_want_r    <= n_want_r;
        r_want_g    <= n_want_g;
        r_want_b    <= n_want_b;
        r_best_i    <= n_best_i;
        r_best_sum  <= n_best_sum;
        r_best_r    <= n_best_r;
        r_best_g    <= n_best_g;
        r_best_b    <= n_best_b;
        r_best_dr   <= n_best_dr;
        r_best_dg   <= n_best_dg;
        r_best_db   <= n_best_db;
        r_out_pixel <= n_out_pixel;
    end

    `NPS_ASSERT_NXT(a_find_starts, w_in_acc && (i_in_func == FUNC_FIND),
        (r_state == ST_SCAN) || (r_state == ST_DONE), "find request did not start a search")
    `NPS_ASSERT_NXT(a_write_stays_idle, w_in_acc && (i_in_func == FUNC_WRITE),
        r_state == ST_IDLE, "write request left the idle state")
    `NPS_ASSERT_IMP(a_pend_in_scan, r_state != ST_SCAN, !r_pend,
        "read pending outside a scan")
    `NPS_ASSERT_NXT(a_done_loads_out, (r_state == ST_DONE) && (!r_out_valid || i_out_ready),
        r_out_valid && (r_state == ST_IDLE), "finished search did not load the result")

endmodule
